// ===== design/imu_register_poll_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// IMU poll sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk, masked during reset.
// ----------------------------------------------------------------------------
`ifndef IMU_REGISTER_POLL_SEQUENCER_DEFINES_SVH
`define IMU_REGISTER_POLL_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define IMUPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMUPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/imups_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU poll sequencer package
// Codes, shared types and the data register address helper.
// ----------------------------------------------------------------------------
package imups_pkg;

  localparam int unsigned BYTE_COUNT = 12;
  localparam int unsigned IDX_W      = $clog2(BYTE_COUNT);
  localparam int unsigned VAL_COUNT  = BYTE_COUNT / 2;
  localparam int unsigned AXES       = VAL_COUNT / 2;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BYTE_COUNT - 1);

  // bus command codes
  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_START_TX  = 2'd1,
    CMD_LAST_TX   = 2'd2,
    CMD_SINGLE_RX = 2'd3
  } cmd_t;

  // input event codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_DONE = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_PWR_REG  = 3'd0,
    REG_GYRO_PWR_VAL  = 3'd1,
    REG_ACCEL_PWR_REG = 3'd2,
    REG_ACCEL_PWR_VAL = 3'd3,
    REG_GYRO_BASE     = 3'd4,
    REG_ACCEL_BASE    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] gyro_power_reg;
    logic [7:0] gyro_power_value;
    logic [7:0] accel_power_reg;
    logic [7:0] accel_power_value;
    logic [7:0] gyro_base_reg;
    logic [7:0] accel_base_reg;
  } cfg_t;

  // control to data path: byte store write and assembly strobe
  typedef struct packed {
    logic             store_en;
    logic [IDX_W-1:0] store_idx;
    logic             assemble;
  } store_ev_t;

  // bus address of data byte idx: gyro bytes first, then accel, 8-bit wrap
  function automatic logic [7:0] data_addr(input logic [IDX_W-1:0] idx,
                                           input logic [7:0] gbase,
                                           input logic [7:0] abase);
    logic [7:0] off;
    off = 8'(idx);
    if (idx < IDX_W'(VAL_COUNT)) begin
      return 8'(gbase + off);
    end
    return 8'(abase + 8'(off - 8'(VAL_COUNT)));
  endfunction

endpackage

// ===== design/imups_cfg.sv =====
// ----------------------------------------------------------------------------
// IMU poll sequencer configuration registers
// Six 8-bit registers written through a valid/ready port.
// ----------------------------------------------------------------------------
module imups_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [imups_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output imups_pkg::cfg_t               cfg
);
  import imups_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg      = cfg_r;

  // register decode; unused indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GYRO_PWR_REG:  cfg_nxt.gyro_power_reg    = cfg_data;
        REG_GYRO_PWR_VAL:  cfg_nxt.gyro_power_value  = cfg_data;
        REG_ACCEL_PWR_REG: cfg_nxt.accel_power_reg   = cfg_data;
        REG_ACCEL_PWR_VAL: cfg_nxt.accel_power_value = cfg_data;
        REG_GYRO_BASE:     cfg_nxt.gyro_base_reg     = cfg_data;
        REG_ACCEL_BASE:    cfg_nxt.accel_base_reg    = cfg_data;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/imups_ctrl.sv =====
// ----------------------------------------------------------------------------
// IMU poll sequencer control
// Write/read sequence state and the bus command for each event word.
// ----------------------------------------------------------------------------
module imups_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 action,
  input  imups_pkg::cfg_t      cfg,
  output imups_pkg::cmd_t      cmd,
  output logic [7:0]           tx,
  output imups_pkg::store_ev_t ev
);
  import imups_pkg::*;

  logic             polling_r, polling_nxt;
  logic             reading_r, reading_nxt;
  logic             half_r, half_nxt;
  logic             wr_rem_r, wr_rem_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] idx_dec;

  assign idx_dec = idx_r - IDX_W'(1);

  // event decode
  always_comb begin
    polling_nxt  = polling_r;
    reading_nxt  = reading_r;
    half_nxt     = half_r;
    wr_rem_nxt   = wr_rem_r;
    idx_nxt      = idx_r;
    cmd          = CMD_NONE;
    tx           = '0;
    ev.store_en  = 1'b0;
    ev.store_idx = idx_r;
    ev.assemble  = 1'b0;
    if (action == ACT_TICK) begin
      // tick: power-up write first time, else restart the read
      cmd = CMD_START_TX;
      if (!polling_r) begin
        tx          = cfg.gyro_power_reg;
        polling_nxt = 1'b1;
      end else begin
        tx = data_addr(LAST_IDX, cfg.gyro_base_reg, cfg.accel_base_reg);
      end
    end else if (!reading_r) begin
      // power register writes
      if (!half_r) begin
        cmd      = CMD_LAST_TX;
        tx       = wr_rem_r ? cfg.gyro_power_value : cfg.accel_power_value;
        half_nxt = 1'b1;
      end else begin
        cmd      = CMD_START_TX;
        half_nxt = 1'b0;
        if (wr_rem_r) begin
          wr_rem_nxt = 1'b0;
          tx         = cfg.accel_power_reg;
        end else begin
          reading_nxt = 1'b1;
          tx          = data_addr(idx_r, cfg.gyro_base_reg, cfg.accel_base_reg);
        end
      end
    end else begin
      // data byte reads
      if (!half_r) begin
        cmd      = CMD_SINGLE_RX;
        half_nxt = 1'b1;
      end else begin
        ev.store_en = (idx_r < IDX_W'(BYTE_COUNT));
        half_nxt    = 1'b0;
        if (idx_r == '0) begin
          ev.assemble = 1'b1;
          idx_nxt     = LAST_IDX;
        end else begin
          idx_nxt = idx_dec;
          cmd     = CMD_START_TX;
          tx      = data_addr(idx_dec, cfg.gyro_base_reg, cfg.accel_base_reg);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polling_r <= 1'b0;
      reading_r <= 1'b0;
      half_r    <= 1'b0;
      wr_rem_r  <= 1'b1;
      idx_r     <= LAST_IDX;
    end else if (in_fire) begin
      polling_r <= polling_nxt;
      reading_r <= reading_nxt;
      half_r    <= half_nxt;
      wr_rem_r  <= wr_rem_nxt;
      idx_r     <= idx_nxt;
    end
  end

endmodule

// ===== design/imups_data.sv =====
// ----------------------------------------------------------------------------
// IMU poll sequencer data path
// Received byte store and the six held 16-bit sample values.
// ----------------------------------------------------------------------------
module imups_data (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           rx_byte,
  input  imups_pkg::store_ev_t ev,
  output logic signed [15:0]   held [imups_pkg::VAL_COUNT]
);
  import imups_pkg::*;

  logic [7:0]         store_r [BYTE_COUNT];
  logic signed [15:0] held_r  [VAL_COUNT];
  logic [7:0]         cur     [BYTE_COUNT];

  // byte 0 arrives in the same word that triggers assembly
  always_comb begin
    for (int i = 0; i < BYTE_COUNT; i++) begin
      cur[i] = store_r[i];
    end
    cur[0] = rx_byte;
  end

  // byte store, no reset
  always_ff @(posedge clk) begin
    if (in_fire && ev.store_en) begin
      store_r[ev.store_idx] <= rx_byte;
    end
  end

  // held values, low byte first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < VAL_COUNT; k++) begin
        held_r[k] <= '0;
      end
    end else if (in_fire && ev.assemble) begin
      for (int k = 0; k < VAL_COUNT; k++) begin
        held_r[k] <= {cur[2*k+1], cur[2*k]};
      end
    end
  end

  assign held = held_r;

endmodule

// ===== design/imu_register_poll_sequencer.sv =====
// ----------------------------------------------------------------------------
// IMU register poll sequencer
// An accepted word's result is in one output register in the next cycle.
// Throughput: one event word per cycle while in_stall is low; the sequence
// state and byte store update in the accepting cycle.
// Reset (rst_n low, synchronous): sequence back to waiting for the first
// tick, configuration and held values cleared, output register emptied.
// ----------------------------------------------------------------------------
`include "imu_register_poll_sequencer_defines.svh"

module imu_register_poll_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  // event channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_rx_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_bus_command,
  output logic                            out_read_direction,
  output logic [7:0]                      out_tx_byte,
  output logic                            out_sample_valid,
  output logic signed [15:0]              out_gyro_x,
  output logic signed [15:0]              out_gyro_y,
  output logic signed [15:0]              out_gyro_z,
  output logic signed [15:0]              out_accel_x,
  output logic signed [15:0]              out_accel_y,
  output logic signed [15:0]              out_accel_z,
  // configuration port
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [imups_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data
);
  import imups_pkg::*;

  cfg_t               cfg;
  cmd_t               cmd;
  logic [7:0]         tx;
  store_ev_t          ev;
  logic signed [15:0] held [VAL_COUNT];
  logic               in_fire;

  logic       out_valid_r, out_valid_nxt;
  cmd_t       cmd_r;
  logic       dir_r;
  logic [7:0] tx_r;
  logic       smp_r;

  // handshake: take a word whenever the result register is free or draining
  assign in_stall      = out_valid_r & out_stall;
  assign in_fire       = in_valid & ~in_stall;
  assign out_valid_nxt = in_fire | (out_valid_r & out_stall);

  imups_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  imups_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .action  (in_action),
    .cfg     (cfg),
    .cmd     (cmd),
    .tx      (tx),
    .ev      (ev)
  );

  imups_data u_data (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_rx_byte),
    .ev      (ev),
    .held    (held)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd;
      dir_r <= (cmd == CMD_SINGLE_RX);
      tx_r  <= tx;
      smp_r <= ev.assemble;
    end
  end

  // held values only change on an accepted word, so they track the result
  assign out_valid          = out_valid_r;
  assign out_bus_command    = cmd_r;
  assign out_read_direction = dir_r;
  assign out_tx_byte        = tx_r;
  assign out_sample_valid   = smp_r;
  assign out_gyro_x         = held[0];
  assign out_gyro_y         = held[1];
  assign out_gyro_z         = held[2];
  assign out_accel_x        = held[AXES];
  assign out_accel_y        = held[AXES+1];
  assign out_accel_z        = held[AXES+2];

  // checks
  `IMUPS_ASSERT_NEXT(a_fire_fills, in_fire, out_valid_r, "accepted word lost")
  `IMUPS_ASSERT_NOW(a_sample_idle, out_valid_r && smp_r, cmd_r == CMD_NONE && !dir_r,
                    "sample word carries a bus command")
  `IMUPS_ASSERT_NOW(a_rx_dir, out_valid_r && dir_r, cmd_r == CMD_SINGLE_RX && tx_r == 8'd0,
                    "read direction without single receive")

endmodule

// ===== tb/imu_register_poll_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// IMU register poll sequencer testbench
// Drives tick and transfer-done words into the sequencer and checks every
// result word against a cycle-free predictor of the command sequence and the
// assembled sample values. A short scripted run covers the power writes, both
// kinds of event and the value extremes. Random runs follow under several
// configurations and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module imu_register_poll_sequencer_tb;
  import imups_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SCRIPT_LEN     = 30;
  localparam int RANDOM_PER_RUN = 270;

  // one scripted event word, with optional hand-typed command fields
  typedef struct packed {
    logic       act;
    logic [7:0] rx;
    logic       typed;
    cmd_t       cmd;
    logic       dir;
    logic [7:0] tx;
    logic       sv;
  } stim_row_t;

  // one result word
  typedef struct packed {
    cmd_t             cmd;
    logic             dir;
    logic [7:0]       tx;
    logic             sv;
    logic [5:0][15:0] vals;
  } poll_result_t;

  // power writes and the start of reading, then one full pass of 12 bytes
  // giving -32768, 32767, -1, 0, 1 and 0xaa55
  localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
    // transfer done before the first tick: write sequence runs anyway
    '{ACT_DONE, 8'h00, 1'b1, CMD_LAST_TX,   1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hff, 1'b1, CMD_START_TX,  1'b0, 8'h00, 1'b0},
    // first tick sends the gyro power address
    '{ACT_TICK, 8'h5a, 1'b1, CMD_START_TX,  1'b0, 8'hff, 1'b0},
    // tick while polling, with a write still in progress
    '{ACT_TICK, 8'ha5, 1'b1, CMD_START_TX,  1'b0, 8'h05, 1'b0},
    '{ACT_DONE, 8'h00, 1'b1, CMD_LAST_TX,   1'b0, 8'hff, 1'b0},
    '{ACT_DONE, 8'h00, 1'b1, CMD_START_TX,  1'b0, 8'h05, 1'b0},
    '{ACT_DONE, 8'h3c, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'haa, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hc3, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h55, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'h3c, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h00, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hc3, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h01, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'h3c, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h00, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hc3, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h00, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'h3c, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'hff, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hc3, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'hff, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'h3c, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h7f, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hc3, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'hff, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'h3c, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    '{ACT_DONE, 8'h80, 1'b0, CMD_NONE,      1'b0, 8'h00, 1'b0},
    '{ACT_DONE, 8'hc3, 1'b1, CMD_SINGLE_RX, 1'b1, 8'h00, 1'b0},
    // byte 0 closes the pass: sample flagged, no command
    '{ACT_DONE, 8'h00, 1'b1, CMD_NONE,      1'b0, 8'h00, 1'b1}
  };

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic                 in_action    = 1'b0;
  logic [7:0]           in_rx_byte   = 8'h00;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic [1:0]           out_bus_command;
  logic                 out_read_direction;
  logic [7:0]           out_tx_byte;
  logic                 out_sample_valid;
  logic signed [15:0]   out_gyro_x;
  logic signed [15:0]   out_gyro_y;
  logic signed [15:0]   out_gyro_z;
  logic signed [15:0]   out_accel_x;
  logic signed [15:0]   out_accel_y;
  logic signed [15:0]   out_accel_z;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [7:0]           cfg_data     = 8'h00;

  // predictor state, at its reset values
  cfg_t                 regs         = '0;
  logic                 polling      = 1'b0;
  logic                 reading      = 1'b0;
  logic                 second_half  = 1'b0;
  logic                 writes_left  = 1'b1;
  logic [IDX_W-1:0]     byte_idx     = LAST_IDX;
  logic [7:0]           rx_bytes [BYTE_COUNT];
  logic [5:0][15:0]     held_vals    = '0;

  poll_result_t         pending_results [$];
  int                   fault_count  = 0;
  int                   idle_pct     = 0;
  int                   stall_pct    = 0;
  int                   quiet_cycles = 0;
  string                axis_name [6] = '{"gyro_x", "gyro_y", "gyro_z",
                                          "accel_x", "accel_y", "accel_z"};

  imu_register_poll_sequencer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_action          (in_action),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bus_command    (out_bus_command),
    .out_read_direction (out_read_direction),
    .out_tx_byte        (out_tx_byte),
    .out_sample_valid   (out_sample_valid),
    .out_gyro_x         (out_gyro_x),
    .out_gyro_y         (out_gyro_y),
    .out_gyro_z         (out_gyro_z),
    .out_accel_x        (out_accel_x),
    .out_accel_y        (out_accel_y),
    .out_accel_z        (out_accel_z),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sensor register address of data byte idx: gyro bytes 0..5, accel 6..11
  function automatic logic [7:0] sensor_addr(input logic [IDX_W-1:0] idx);
    if (idx < IDX_W'(VAL_COUNT)) begin
      return 8'(regs.gyro_base_reg + 8'(idx));
    end
    return 8'(regs.accel_base_reg + (8'(idx) - 8'(VAL_COUNT)));
  endfunction

  // next command word for one event; advances the predicted sequence
  task automatic predict_command(input logic act, input logic [7:0] rx,
                                 output poll_result_t res);
    res = '0;
    if (act == ACT_TICK) begin
      res.cmd = CMD_START_TX;
      if (!polling) begin
        res.tx  = regs.gyro_power_reg;
        polling = 1'b1;
      end else begin
        res.tx = sensor_addr(LAST_IDX);
      end
    end else if (!reading) begin
      // power writes: address then value, gyro first
      if (!second_half) begin
        res.cmd     = CMD_LAST_TX;
        res.tx      = writes_left ? regs.gyro_power_value : regs.accel_power_value;
        second_half = 1'b1;
      end else begin
        res.cmd = CMD_START_TX;
        if (writes_left) begin
          writes_left = 1'b0;
          res.tx      = regs.accel_power_reg;
        end else begin
          reading = 1'b1;
          res.tx  = sensor_addr(byte_idx);
        end
        second_half = 1'b0;
      end
    end else if (!second_half) begin
      res.cmd     = CMD_SINGLE_RX;
      res.dir     = 1'b1;
      second_half = 1'b1;
    end else begin
      // byte arrived: store it, then next address or assemble the sample
      rx_bytes[byte_idx] = rx;
      second_half        = 1'b0;
      if (byte_idx == '0) begin
        for (int k = 0; k < 6; k++) begin
          held_vals[k] = {rx_bytes[2*k+1], rx_bytes[2*k]};
        end
        res.sv   = 1'b1;
        byte_idx = LAST_IDX;
      end else begin
        byte_idx = byte_idx - 1'b1;
        res.cmd  = CMD_START_TX;
        res.tx   = sensor_addr(byte_idx);
      end
    end
    res.vals = held_vals;
  endtask

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      note_fault($sformatf("%s expected %h got %h", name, want, got));
    end
  endtask

  // send one event word, with random idle cycles in front of it
  task automatic send_event(input stim_row_t row);
    poll_result_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= row.act;
    in_rx_byte <= row.rx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(row.act, row.rx, res);
    if (row.typed) begin
      res.cmd = row.cmd;
      res.dir = row.dir;
      res.tx  = row.tx;
      res.sv  = row.sv;
    end
    pending_results.push_back(res);
  endtask

  // hold the sender until every pending result word is out
  task automatic drain_results();
    if (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    unique case (idx)
      REG_GYRO_PWR_REG:  regs.gyro_power_reg    = val;
      REG_GYRO_PWR_VAL:  regs.gyro_power_value  = val;
      REG_ACCEL_PWR_REG: regs.accel_power_reg   = val;
      REG_ACCEL_PWR_VAL: regs.accel_power_value = val;
      REG_GYRO_BASE:     regs.gyro_base_reg     = val;
      REG_ACCEL_BASE:    regs.accel_base_reg    = val;
      default: ;
    endcase
  endtask

  // drain, then rewrite all six registers back to back
  task automatic program_regs(input logic [7:0] gpr, input logic [7:0] gpv,
                              input logic [7:0] apr, input logic [7:0] apv,
                              input logic [7:0] gb, input logic [7:0] ab);
    drain_results();
    cfg_write(REG_GYRO_PWR_REG, gpr);
    cfg_write(REG_GYRO_PWR_VAL, gpv);
    cfg_write(REG_ACCEL_PWR_REG, apr);
    cfg_write(REG_ACCEL_PWR_VAL, apv);
    cfg_write(REG_GYRO_BASE, gb);
    cfg_write(REG_ACCEL_BASE, ab);
    cfg_valid <= 1'b0;
  endtask

  // result side stall
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // result word check against the oldest prediction
  always @(posedge clk) begin : result_check
    poll_result_t     want;
    logic [5:0][15:0] got_vals;
    if (rst_n && out_valid && !out_stall) begin
      got_vals = {out_accel_z, out_accel_y, out_accel_x,
                  out_gyro_z, out_gyro_y, out_gyro_x};
      if (pending_results.size() == 0) begin
        note_fault("result word with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("bus_command", 16'(want.cmd), 16'(out_bus_command));
        check_field("read_direction", 16'(want.dir), 16'(out_read_direction));
        check_field("tx_byte", 16'(want.tx), 16'(out_tx_byte));
        check_field("sample_valid", 16'(want.sv), 16'(out_sample_valid));
        for (int k = 0; k < 6; k++) begin
          check_field(axis_name[k], want.vals[k], got_vals[k]);
        end
      end
    end
  end

  // watchdog: cycles in which no word moves on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // main sequence
  initial begin
    stim_row_t row;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scripted run, no idling
    program_regs(8'hff, 8'h00, 8'h00, 8'hff, 8'd250, 8'd0);
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_event(SCRIPT[i]);
    end

    // random runs: mostly transfer-done words, a few ticks in between
    for (int run = 0; run < 4; run++) begin
      case (run)
        0: begin
          program_regs(8'h00, 8'hff, 8'hff, 8'h00, 8'd0, 8'd250);
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(250)), 8'($urandom_range(250)));
          idle_pct  = 85;
          stall_pct = 0;
        end
        2: begin
          program_regs(8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'd250, 8'd250);
          idle_pct  = 0;
          stall_pct = 85;
        end
        default: begin
          program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(250)), 8'($urandom_range(250)));
          idle_pct  = 31;
          stall_pct = 31;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_RUN; n++) begin
        row       = '0;
        row.act   = ($urandom_range(99) < 8) ? ACT_TICK : ACT_DONE;
        row.rx    = 8'($urandom_range(255));
        row.typed = 1'b0;
        send_event(row);
        if ($urandom_range(49) == 0) begin
          drain_results();
        end
      end
    end

    // wind down
    in_valid  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/imups_pkg.sv
design/imups_cfg.sv
design/imups_ctrl.sv
design/imups_data.sv
design/imu_register_poll_sequencer.sv
tb/imu_register_poll_sequencer_tb.sv
